// ----- rtl/core/dpt_pkg.sv -----
// shared types and constants of the damped pluck tone generator
// used by dpt_ctrl, dpt_datapath and damped_pluck_tone_generator
package dpt_pkg;

    localparam logic [31:0] LCG_MUL    = 32'd1664525;
    localparam logic [31:0] LCG_ADD    = 32'd1013904223;
    localparam logic [31:0] SEED_START = 32'd12345;
    localparam logic [31:0] SQRT3_Q24  = 32'd29058990;
    localparam logic [31:0] POLY_A     = 32'd26353589;
    localparam logic [31:0] POLY_B     = 32'd10764138;
    localparam logic [31:0] POLY_C     = 32'd1187765;
    localparam logic [24:0] UNITY_Q24  = 25'd16777216;
    localparam logic [24:0] ENV_MAX    = 25'h1FF_FFFF;

    localparam int ACC_W = 30;
    localparam logic signed [ACC_W-1:0] SAT_HI = 30'sd8388607;
    localparam logic signed [ACC_W-1:0] SAT_LO = -30'sd8388608;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_OPEN  = 2'd1;
    localparam logic [1:0] STATUS_CANCELLED = 2'd2;

    typedef enum logic [2:0] {
        REG_ENABLED,
        REG_STEP_FIRST,
        REG_STEP_SECOND,
        REG_AMPLITUDE,
        REG_SECOND_LEVEL,
        REG_DECAY,
        REG_ONSET,
        REG_NOISE_LEVEL
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_AE,
        ST_X1,
        ST_C1,
        ST_B1,
        ST_A1,
        ST_T1,
        ST_LEVEL,
        ST_X2,
        ST_C2,
        ST_B2,
        ST_A2,
        ST_T2,
        ST_ENV1,
        ST_ENV2,
        ST_UPDATE,
        ST_LCG0,
        ST_LCG1,
        ST_LCG2,
        ST_LCG3,
        ST_LCG4,
        ST_SQRT,
        ST_NOISE,
        ST_NACC,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_AMP_ENV,
        MUL_X_SQ,
        MUL_C,
        MUL_B,
        MUL_A,
        MUL_TONE,
        MUL_LEVEL,
        MUL_ENV,
        MUL_LCG_SEED,
        MUL_LCG_CHAIN,
        MUL_SQRT3,
        MUL_NOISE
    } mul_sel_t;

    typedef enum logic [3:0] {
        CAP_NONE,
        CAP_AE,
        CAP_X2,
        CAP_A2,
        CAP_TONE,
        CAP_UPDATE,
        CAP_COUNT,
        CAP_SEED,
        CAP_NOISE
    } cap_sel_t;

    typedef struct packed {
        logic     accept;
        logic     load_out;
        logic     part;
        mul_sel_t mul_sel;
        cap_sel_t cap;
    } cmd_t;

    typedef struct packed {
        logic enabled;
        logic err;
        logic tone_active;
        logic second_on;
        logic noise_on;
        logic out_busy;
    } stat_t;

endpackage

// ----- rtl/core/damped_pluck_tone_generator.sv -----
// damped pluck tone generator: top level, joins dpt_ctrl and dpt_datapath; uses dpt_pkg
// one item at a time: the input stalls from the transfer until the result is loaded; the
// time per item is set by the one shared 32x32 multiplier, up to 19 products a sample,
// and by output stalls; the result goes to an output register that holds it while the
// next item is taken in; async active-low reset clears all control state, registers to
// their defaults, generator state to its start values
module damped_pluck_tone_generator #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int SAMPLE_BITS      = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               start_req,
    input  logic               cancel,
    input  logic               last_sample,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] sample_word,
    output logic [1:0]         status,
    output logic               last_out
);
    import dpt_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    dpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    dpt_datapath #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .SAMPLE_BITS      (SAMPLE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .start_req   (start_req),
        .cancel      (cancel),
        .last_sample (last_sample),
        .out_stall   (out_stall),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .sample_word (sample_word),
        .status      (status),
        .last_out    (last_out)
    );

`ifndef NO_ASSERTIONS
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while an item is in work");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STATUS_OK |-> sample_word == 32'sd0)
        else $error("error status with a nonzero sample word");

    a_low_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sample_word[7:0] == 8'd0)
        else $error("sample word low byte not zero");
`endif

endmodule

// ----- rtl/core/dpt_ctrl.sv -----
// sequencer for the tone generator: steps the shared multiplier through one sample
// depends on dpt_pkg
module dpt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  dpt_pkg::stat_t stat,
    output dpt_pkg::cmd_t  cmd
);
    import dpt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        in_stall     = 1'b1;
        cmd.accept   = 1'b0;
        cmd.load_out = 1'b0;
        cmd.part     = 1'b0;
        cmd.mul_sel  = MUL_NONE;
        cmd.cap      = CAP_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (!stat.enabled || stat.err)
                begin
                    state_next = ST_DONE;
                end
                else if (stat.tone_active)
                begin
                    state_next = ST_AE;
                end
                else
                begin
                    cmd.cap    = CAP_COUNT;
                    state_next = stat.noise_on ? ST_LCG0 : ST_DONE;
                end
            end
            ST_AE:
            begin
                cmd.mul_sel = MUL_AMP_ENV;
                state_next  = ST_X1;
            end
            ST_X1:
            begin
                cmd.mul_sel = MUL_X_SQ;
                cmd.cap     = CAP_AE;
                state_next  = ST_C1;
            end
            ST_C1:
            begin
                cmd.mul_sel = MUL_C;
                cmd.cap     = CAP_X2;
                state_next  = ST_B1;
            end
            ST_B1:
            begin
                cmd.mul_sel = MUL_B;
                state_next  = ST_A1;
            end
            ST_A1:
            begin
                cmd.mul_sel = MUL_A;
                state_next  = ST_T1;
            end
            ST_T1:
            begin
                cmd.mul_sel = MUL_TONE;
                state_next  = stat.second_on ? ST_LEVEL : ST_ENV1;
            end
            ST_LEVEL:
            begin
                cmd.mul_sel = MUL_LEVEL;
                cmd.cap     = CAP_TONE;
                state_next  = ST_X2;
            end
            ST_X2:
            begin
                cmd.part    = 1'b1;
                cmd.mul_sel = MUL_X_SQ;
                cmd.cap     = CAP_A2;
                state_next  = ST_C2;
            end
            ST_C2:
            begin
                cmd.part    = 1'b1;
                cmd.mul_sel = MUL_C;
                cmd.cap     = CAP_X2;
                state_next  = ST_B2;
            end
            ST_B2:
            begin
                cmd.part    = 1'b1;
                cmd.mul_sel = MUL_B;
                state_next  = ST_A2;
            end
            ST_A2:
            begin
                cmd.part    = 1'b1;
                cmd.mul_sel = MUL_A;
                state_next  = ST_T2;
            end
            ST_T2:
            begin
                cmd.part    = 1'b1;
                cmd.mul_sel = MUL_TONE;
                state_next  = ST_ENV2;
            end
            ST_ENV1:
            begin
                cmd.mul_sel = MUL_ENV;
                cmd.cap     = CAP_TONE;
                state_next  = ST_UPDATE;
            end
            ST_ENV2:
            begin
                cmd.part    = 1'b1;
                cmd.mul_sel = MUL_ENV;
                cmd.cap     = CAP_TONE;
                state_next  = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.cap    = CAP_UPDATE;
                state_next = stat.noise_on ? ST_LCG0 : ST_DONE;
            end
            ST_LCG0:
            begin
                cmd.mul_sel = MUL_LCG_SEED;
                state_next  = ST_LCG1;
            end
            ST_LCG1:
            begin
                cmd.mul_sel = MUL_LCG_CHAIN;
                cmd.cap     = CAP_SEED;
                state_next  = ST_LCG2;
            end
            ST_LCG2:
            begin
                cmd.mul_sel = MUL_LCG_CHAIN;
                cmd.cap     = CAP_SEED;
                state_next  = ST_LCG3;
            end
            ST_LCG3:
            begin
                cmd.mul_sel = MUL_LCG_CHAIN;
                cmd.cap     = CAP_SEED;
                state_next  = ST_LCG4;
            end
            ST_LCG4:
            begin
                cmd.cap    = CAP_SEED;
                state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                cmd.mul_sel = MUL_SQRT3;
                state_next  = ST_NOISE;
            end
            ST_NOISE:
            begin
                cmd.mul_sel = MUL_NOISE;
                state_next  = ST_NACC;
            end
            ST_NACC:
            begin
                cmd.cap    = CAP_NOISE;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/dpt_datapath.sv -----
// datapath of the tone generator: registers, shared multiplier, accumulator, output stage
// depends on dpt_pkg; driven by dpt_ctrl commands
module dpt_datapath #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int SAMPLE_BITS      = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               start_req,
    input  logic               cancel,
    input  logic               last_sample,
    input  logic               out_stall,
    input  dpt_pkg::cmd_t      cmd,
    output dpt_pkg::stat_t     stat,
    output logic               out_valid,
    output logic signed [31:0] sample_word,
    output logic [1:0]         status,
    output logic               last_out
);
    import dpt_pkg::*;

    // power-of-two table depth: phase keeps its top PHASE_BITS bits
    localparam int PHASE_BITS = $clog2(SINE_TABLE_DEPTH);
    localparam logic [31:0] PHASE_MASK = ~((32'd1 << (32 - PHASE_BITS)) - 32'd1);
    localparam logic [23:0] SAMPLE_MASK = ~((24'd1 << (24 - SAMPLE_BITS)) - 24'd1);

    logic        enabled_reg;
    logic [31:0] step_first_reg;
    logic [31:0] step_second_reg;
    logic [23:0] amplitude_reg;
    logic [15:0] second_level_reg;
    logic [24:0] decay_reg;
    logic [23:0] onset_reg;
    logic [23:0] noise_level_reg;

    logic [31:0] phase_first_reg;
    logic [31:0] phase_second_reg;
    logic [24:0] envelope_reg;
    logic [23:0] count_reg;
    logic [31:0] seed_reg;
    logic [1:0]  capture_error_reg;

    logic [63:0]             prod_reg;
    logic [24:0]             ae_reg;
    logic [24:0]             x2_reg;
    logic [26:0]             a2_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [25:0]      sum_reg;
    logic                    last_reg;
    logic                    out_valid_reg;
    logic signed [31:0]      sample_word_reg;
    logic [1:0]              status_reg;
    logic                    last_out_reg;

    logic [31:0]             phase_sel;
    logic [31:0]             tp;
    logic [30:0]             fold;
    logic [24:0]             x;
    logic [31:0]             prod_hi;
    logic [25:0]             sin_y;
    logic [23:0]             sin_mag;
    logic [31:0]             seed_next;
    logic signed [25:0]      uniform;
    logic [25:0]             sum_mag;
    logic [25:0]             env_prod;
    logic [24:0]             env_next;
    logic signed [ACC_W-1:0] tone_term;
    logic signed [ACC_W-1:0] noise_term;
    logic [31:0]             mul_a;
    logic [31:0]             mul_b;
    logic [63:0]             prod_next;
    logic [23:0]             sat_value;
    logic                    restart;

    always_comb
    begin
        phase_sel = cmd.part ? phase_second_reg : phase_first_reg;
        tp        = phase_sel & PHASE_MASK;
        fold      = tp[30] ? (31'h4000_0000 - {1'b0, tp[29:0]}) : {1'b0, tp[29:0]};
        x         = fold[30:6];
        prod_hi   = prod_reg[55:24];
        sin_y     = prod_reg[49:24];
        sin_mag   = (sin_y > {1'b0, UNITY_Q24}) ? 24'h80_0000 : sin_y[24:1];
        seed_next = prod_reg[31:0] + LCG_ADD;
        uniform   = $signed({2'b00, seed_next[31:8]}) - 26'sd8388608;
        sum_mag   = sum_reg[25] ? 26'(-sum_reg) : 26'(sum_reg);
        env_prod  = prod_reg[49:24];
        env_next  = (env_prod > {1'b0, ENV_MAX}) ? ENV_MAX : env_prod[24:0];
        tone_term = $signed({1'b0, prod_reg[51:23]});
        if (phase_sel[31])
        begin
            tone_term = -tone_term;
        end
        noise_term = $signed({3'b000, prod_reg[50:24]});
        if (sum_reg[25])
        begin
            noise_term = -noise_term;
        end
        if (acc_reg > SAT_HI)
        begin
            sat_value = 24'h7F_FFFF;
        end
        else if (acc_reg < SAT_LO)
        begin
            sat_value = 24'h80_0000;
        end
        else
        begin
            sat_value = acc_reg[23:0];
        end
    end

    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (cmd.mul_sel)
            MUL_AMP_ENV:
            begin
                mul_a = {8'd0, amplitude_reg};
                mul_b = {7'd0, envelope_reg};
            end
            MUL_X_SQ:
            begin
                mul_a = {7'd0, x};
                mul_b = {7'd0, x};
            end
            MUL_C:
            begin
                mul_a = POLY_C;
                mul_b = prod_hi;
            end
            MUL_B:
            begin
                mul_a = POLY_B - prod_hi;
                mul_b = {7'd0, x2_reg};
            end
            MUL_A:
            begin
                mul_a = POLY_A - prod_hi;
                mul_b = {7'd0, x};
            end
            MUL_TONE:
            begin
                mul_a = cmd.part ? {5'd0, a2_reg} : {7'd0, ae_reg};
                mul_b = {8'd0, sin_mag};
            end
            MUL_LEVEL:
            begin
                mul_a = {7'd0, ae_reg};
                mul_b = {16'd0, second_level_reg};
            end
            MUL_ENV:
            begin
                mul_a = {7'd0, envelope_reg};
                mul_b = {7'd0, decay_reg};
            end
            MUL_LCG_SEED:
            begin
                mul_a = seed_reg;
                mul_b = LCG_MUL;
            end
            MUL_LCG_CHAIN:
            begin
                mul_a = seed_next;
                mul_b = LCG_MUL;
            end
            MUL_SQRT3:
            begin
                mul_a = {6'd0, sum_mag};
                mul_b = SQRT3_Q24;
            end
            MUL_NOISE:
            begin
                mul_a = prod_hi;
                mul_b = {8'd0, noise_level_reg};
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign prod_next = 64'(mul_a) * 64'(mul_b);
    assign restart   = cmd.accept && enabled_reg && start_req;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg      <= 1'b0;
            step_first_reg   <= 32'd0;
            step_second_reg  <= 32'd0;
            amplitude_reg    <= 24'd0;
            second_level_reg <= 16'd0;
            decay_reg        <= UNITY_Q24;
            onset_reg        <= 24'd0;
            noise_level_reg  <= 24'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ENABLED:      enabled_reg      <= cfg_data[0];
                REG_STEP_FIRST:   step_first_reg   <= cfg_data;
                REG_STEP_SECOND:  step_second_reg  <= cfg_data;
                REG_AMPLITUDE:    amplitude_reg    <= cfg_data[23:0];
                REG_SECOND_LEVEL: second_level_reg <= cfg_data[15:0];
                REG_DECAY:        decay_reg        <= cfg_data[24:0];
                REG_ONSET:        onset_reg        <= cfg_data[23:0];
                REG_NOISE_LEVEL:  noise_level_reg  <= cfg_data[23:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_first_reg   <= 32'd0;
            phase_second_reg  <= 32'd0;
            envelope_reg      <= UNITY_Q24;
            count_reg         <= 24'd0;
            seed_reg          <= SEED_START;
            capture_error_reg <= STATUS_OK;
        end
        else if (restart)
        begin
            phase_first_reg   <= 32'd0;
            phase_second_reg  <= 32'd0;
            envelope_reg      <= UNITY_Q24;
            count_reg         <= 24'd0;
            seed_reg          <= SEED_START;
            capture_error_reg <= cancel ? STATUS_CANCELLED : STATUS_OK;
        end
        else
        begin
            case (cmd.cap)
                CAP_UPDATE:
                begin
                    phase_first_reg  <= phase_first_reg + step_first_reg;
                    phase_second_reg <= phase_second_reg + step_second_reg;
                    envelope_reg     <= env_next;
                end
                CAP_COUNT:
                begin
                    count_reg <= count_reg + 24'd1;
                end
                CAP_SEED:
                begin
                    seed_reg <= seed_next;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cmd.accept)
        begin
            acc_reg  <= '0;
            sum_reg  <= '0;
            last_reg <= last_sample;
        end
        else
        begin
            case (cmd.cap)
                CAP_AE:    ae_reg  <= prod_reg[48:24];
                CAP_X2:    x2_reg  <= prod_reg[48:24];
                CAP_A2:    a2_reg  <= prod_reg[40:14];
                CAP_TONE:  acc_reg <= acc_reg + tone_term;
                CAP_SEED:  sum_reg <= sum_reg + uniform;
                CAP_NOISE: acc_reg <= acc_reg + noise_term;
                default:
                begin
                end
            endcase
        end
        if (cmd.load_out)
        begin
            last_out_reg <= last_reg;
            if (!enabled_reg)
            begin
                status_reg      <= STATUS_NOT_OPEN;
                sample_word_reg <= 32'sd0;
            end
            else if (capture_error_reg != STATUS_OK)
            begin
                status_reg      <= capture_error_reg;
                sample_word_reg <= 32'sd0;
            end
            else
            begin
                status_reg      <= STATUS_OK;
                sample_word_reg <= $signed({sat_value & SAMPLE_MASK, 8'd0});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.enabled     = enabled_reg;
    assign stat.err         = capture_error_reg != STATUS_OK;
    assign stat.tone_active = count_reg >= onset_reg;
    assign stat.second_on   = step_second_reg != 32'd0;
    assign stat.noise_on    = noise_level_reg != 24'd0;
    assign stat.out_busy    = out_valid_reg && out_stall;

    assign out_valid   = out_valid_reg;
    assign sample_word = sample_word_reg;
    assign status      = status_reg;
    assign last_out    = last_out_reg;

endmodule
